// ----- hw/rtl/iwt_pkg.sv -----
// ----------------------------------------------------------------------------
// iwt_pkg
// Shared types, constants and character helpers of the index word tokenizer.
// ----------------------------------------------------------------------------
package iwt_pkg;

  localparam int MAX_WORD_DEF = 64;

  localparam int BYTE_W     = 8;
  localparam int OFS_W      = 32;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;

  // char ring between front and back, holds at least one full word plus one
  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int PTR_W      = RING_AW + 1;

  localparam int DESC_DEPTH = 4;
  localparam int DESC_AW    = $clog2(DESC_DEPTH);

  localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_USCORE = 8'h5F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INDEX_DIGITS      = 2'd0,
    CFG_INTERPRET_SPECIAL = 2'd1,
    CFG_SPECIAL_INDEXABLE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic index_digits;
    logic interpret_special;
    logic special_indexable;
  } cfg_t;

  typedef struct packed {
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } desc_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } ring_wr_t;

  function automatic logic is_indexable(input logic [BYTE_W-1:0] b, input cfg_t cfg);
    logic res;
    res = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
          (b == CH_USCORE);
    if (cfg.index_digits && (b >= 8'h30) && (b <= 8'h39)) res = 1'b1;
    if (cfg.special_indexable &&
        ((b == CH_DASH) || (b == CH_LBRACK) || (b == CH_RBRACK))) res = 1'b1;
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] res;
    res = b;
    if ((b >= 8'h41) && (b <= 8'h5A)) res = b | 8'h20;
    return res;
  endfunction

endpackage

// ----- hw/rtl/iwt_if.sv -----
// ----------------------------------------------------------------------------
// iwt_if
// Valid/ready channels of the index word tokenizer: text in, words out, config.
// ----------------------------------------------------------------------------
interface iwt_in_if import iwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              buffer_last;

  modport source (output valid, output text_byte, output buffer_last, input ready);
  modport sink   (input valid, input text_byte, input buffer_last, output ready);
endinterface

interface iwt_out_if import iwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] word_char;
  logic              word_last;
  logic [OFS_W-1:0]  word_offset;
  logic [SIZE_W-1:0] word_size;

  modport source (output valid, output word_char, output word_last, output word_offset,
                  output word_size, input ready);
  modport sink   (input valid, input word_char, input word_last, input word_offset,
                  input word_size, output ready);
endinterface

interface iwt_cfg_if import iwt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/iwt_ram.sv -----
// ----------------------------------------------------------------------------
// iwt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module iwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/iwt_front.sv -----
// ----------------------------------------------------------------------------
// iwt_front
// Accepts text bytes, classifies them, writes word chars into the char ring
// and queues a descriptor for every finished word.
// ----------------------------------------------------------------------------
module iwt_front import iwt_pkg::*; #(
  parameter int  MAX_WORD = MAX_WORD_DEF,
  localparam int CW       = $clog2(MAX_WORD + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  iwt_in_if.sink           text_i,
  input  cfg_t             cfg_i,
  input  logic [PTR_W-1:0] rd_ptr_i,
  input  logic             desc_full_i,
  output logic             desc_push_o,
  output desc_t            desc_o,
  output ring_wr_t         wr_o
);

  logic [OFS_W-1:0] pos_q, pos_d;
  logic [OFS_W-1:0] start_q, start_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             ib_q, ib_d;
  logic             ao_q, ao_d;
  logic             skip_q, skip_d;
  logic             swal_q, swal_d;
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] cm_q, cm_d;

  logic [PTR_W-1:0]  used;
  logic              acc;
  logic [BYTE_W-1:0] b;
  logic              idx;
  logic              do_add;
  logic              do_emit;
  logic [CW-1:0]     fin_cnt;
  logic [OFS_W-1:0]  fin_start;

  assign used         = wr_q - rd_ptr_i;
  assign text_i.ready = !used[RING_AW] && !desc_full_i;
  assign acc          = text_i.valid && text_i.ready;
  assign b            = text_i.text_byte;
  assign idx          = is_indexable(b, cfg_i);

  always_comb begin
    pos_d       = pos_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    ib_d        = ib_q;
    ao_d        = ao_q;
    skip_d      = skip_q;
    swal_d      = swal_q;
    wr_d        = wr_q;
    cm_d        = cm_q;
    do_add      = 1'b0;
    do_emit     = 1'b0;
    fin_cnt     = '0;
    fin_start   = start_q;
    desc_push_o = 1'b0;
    wr_o.we     = 1'b0;
    wr_o.addr   = wr_q[RING_AW-1:0];
    wr_o.data   = fold_case(b);
    if (acc) begin
      pos_d = pos_q + 1'b1;
      if (swal_q) begin
        swal_d = 1'b0;
      end else if (skip_q && idx) begin
        skip_d = 1'b1;
      end else begin
        skip_d = 1'b0;
        if (idx || ib_q) begin
          if (b == CH_LBRACK) begin
            ao_d = 1'b1;
            ib_d = 1'b1;
          end else begin
            ao_d = 1'b0;
            if (b == CH_RBRACK) ib_d = 1'b0;
          end
          if ((b == CH_DASH) && !ib_q) do_emit = 1'b1;
          else do_add = 1'b1;
        end else if (cfg_i.special_indexable && (b == CH_CARET) && ao_q) begin
          ao_d   = 1'b0;
          do_add = 1'b1;
        end else begin
          ao_d    = 1'b0;
          do_emit = 1'b1;
          if (cfg_i.interpret_special && (b == CH_BSLASH)) swal_d = 1'b1;
        end
      end
      if (do_add) begin
        if (cnt_q >= CW'(MAX_WORD)) begin
          // overlong word: drop it and rewind the ring
          cnt_d  = '0;
          skip_d = 1'b1;
          ib_d   = 1'b0;
          ao_d   = 1'b0;
          wr_d   = cm_q;
        end else begin
          if (cnt_q == '0) start_d = pos_q;
          wr_o.we = 1'b1;
          wr_d    = wr_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      fin_cnt   = cnt_d;
      fin_start = start_d;
      if (do_emit || text_i.buffer_last) begin
        desc_push_o = (fin_cnt != '0);
        cm_d        = wr_d;
        cnt_d       = '0;
        ib_d        = 1'b0;
        ao_d        = 1'b0;
      end
      if (text_i.buffer_last) begin
        skip_d = 1'b0;
        swal_d = 1'b0;
      end
    end
  end

  assign desc_o.offset = fin_start;
  assign desc_o.size   = SIZE_W'(fin_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      cnt_q   <= '0;
      ib_q    <= 1'b0;
      ao_q    <= 1'b0;
      skip_q  <= 1'b0;
      swal_q  <= 1'b0;
      wr_q    <= '0;
      cm_q    <= '0;
    end else begin
      pos_q   <= pos_d;
      start_q <= start_d;
      cnt_q   <= cnt_d;
      ib_q    <= ib_d;
      ao_q    <= ao_d;
      skip_q  <= skip_d;
      swal_q  <= swal_d;
      wr_q    <= wr_d;
      cm_q    <= cm_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_WORD))
    else $error("word count above limit");
  a_open_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - cm_q) == PTR_W'(cnt_q))
    else $error("uncommitted ring chars differ from word count");
  a_swal_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swal_q |-> !skip_q)
    else $error("swallow and skip both set");
  a_bracket_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ib_q |-> (cnt_q != '0))
    else $error("bracket open without a word");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_push_o |-> !desc_full_i)
    else $error("descriptor push into full queue");
`endif

endmodule

// ----- hw/rtl/iwt_desc_fifo.sv -----
// ----------------------------------------------------------------------------
// iwt_desc_fifo
// Short queue of finished word descriptors between front and back.
// ----------------------------------------------------------------------------
module iwt_desc_fifo import iwt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  empty_o,
  output logic  full_o
);

  desc_t              mem_q [DESC_DEPTH];
  logic [DESC_AW:0]   wp_q, rp_q;
  logic [DESC_AW:0]   fill;

  assign fill    = wp_q - rp_q;
  assign full_o  = fill[DESC_AW];
  assign empty_o = (fill == '0);
  assign head_o  = mem_q[rp_q[DESC_AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q[DESC_AW-1:0]] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
    end
  end

endmodule

// ----- hw/rtl/iwt_back.sv -----
// ----------------------------------------------------------------------------
// iwt_back
// Drains finished words from the char ring, one char item per cycle while the
// output is ready, through a RAM read stage and an output register.
// ----------------------------------------------------------------------------
module iwt_back import iwt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  desc_t              head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               re_o,
  output logic [RING_AW-1:0] raddr_o,
  input  logic [BYTE_W-1:0]  rdata_i,
  output logic [PTR_W-1:0]   rd_ptr_o,
  iwt_out_if.source          word_o
);

  logic [PTR_W-1:0]  rd_q;
  logic [SIZE_W-1:0] idx_q;
  logic              s1_v_q;
  logic              s1_last_q;
  logic [OFS_W-1:0]  s1_ofs_q;
  logic [SIZE_W-1:0] s1_size_q;
  logic              out_v_q;
  logic [BYTE_W-1:0] out_char_q;
  logic              out_last_q;
  logic [OFS_W-1:0]  out_ofs_q;
  logic [SIZE_W-1:0] out_size_q;

  logic adv;
  logic issue;
  logic is_last;

  assign adv     = !out_v_q || word_o.ready;
  assign issue   = !empty_i && (!s1_v_q || adv);
  assign is_last = (SIZE_W'(idx_q + 1'b1) == head_i.size);
  assign pop_o   = issue && is_last;
  assign re_o    = issue;
  assign raddr_o = rd_q[RING_AW-1:0];
  assign rd_ptr_o = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      idx_q   <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (issue) begin
        rd_q  <= rd_q + 1'b1;
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end
      if (issue) s1_v_q <= 1'b1;
      else if (adv) s1_v_q <= 1'b0;
      if (adv) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_last_q <= is_last;
      s1_ofs_q  <= head_i.offset;
      s1_size_q <= head_i.size;
    end
    if (s1_v_q && adv) begin
      out_char_q <= rdata_i;
      out_last_q <= s1_last_q;
      out_ofs_q  <= s1_ofs_q;
      out_size_q <= s1_size_q;
    end
  end

  assign word_o.valid       = out_v_q;
  assign word_o.word_char   = out_char_q;
  assign word_o.word_last   = out_last_q;
  assign word_o.word_offset = out_ofs_q;
  assign word_o.word_size   = out_size_q;

endmodule

// ----- hw/rtl/index_word_tokenizer.sv -----
// The first char item of a word passes the word queue, RAM read stage and output
// register after the byte that ends it is taken. Throughput: one text byte per
// cycle in, one char item per cycle out while word_o is ready; the input stalls
// only when the 128-entry char ring or the word queue is full.
// Reset: all control state and config registers clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// index_word_tokenizer
// Splits a text byte stream into lower-cased index words, char by char.
// ----------------------------------------------------------------------------
module index_word_tokenizer import iwt_pkg::*; #(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iwt_cfg_if.sink    cfg_i,
  iwt_in_if.sink     text_i,
  iwt_out_if.source  word_o
);

  cfg_t               cfg_q;
  desc_t              desc_in;
  desc_t              desc_head;
  logic               desc_push;
  logic               desc_pop;
  logic               desc_empty;
  logic               desc_full;
  ring_wr_t           ring_wr;
  logic               ring_re;
  logic [RING_AW-1:0] ring_raddr;
  logic [BYTE_W-1:0]  ring_rdata;
  logic [PTR_W-1:0]   rd_ptr;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_INDEX_DIGITS:      cfg_q.index_digits      <= cfg_i.data;
        CFG_INTERPRET_SPECIAL: cfg_q.interpret_special <= cfg_i.data;
        CFG_SPECIAL_INDEXABLE: cfg_q.special_indexable <= cfg_i.data;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  iwt_front #(
    .MAX_WORD(MAX_WORD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_i     (text_i),
    .cfg_i      (cfg_q),
    .rd_ptr_i   (rd_ptr),
    .desc_full_i(desc_full),
    .desc_push_o(desc_push),
    .desc_o     (desc_in),
    .wr_o       (ring_wr)
  );

  iwt_desc_fifo u_desc_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (desc_push),
    .desc_i (desc_in),
    .pop_i  (desc_pop),
    .head_o (desc_head),
    .empty_o(desc_empty),
    .full_o (desc_full)
  );

  iwt_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_wr.we),
    .waddr_i(ring_wr.addr),
    .wdata_i(ring_wr.data),
    .re_i   (ring_re),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  iwt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (desc_head),
    .empty_i (desc_empty),
    .pop_o   (desc_pop),
    .re_o    (ring_re),
    .raddr_o (ring_raddr),
    .rdata_i (ring_rdata),
    .rd_ptr_o(rd_ptr),
    .word_o  (word_o)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the index word tokenizer. A directed table covers
// field extremes, brackets, caret, dash, backslash swallow, long-word drop and
// buffer end; random text follows under several configs and idle patterns,
// including a long output hold-off. Every char item is checked against an
// in-bench tokenizer model or a fixed expected item from the directed table.
// ----------------------------------------------------------------------------
module tb_top import iwt_pkg::*; ();

  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PAUSE_EVERY    = 60;
  localparam int PHASE_ITEMS    = 64;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] size;
  } char_item_t;

  typedef enum {EXP_MODEL, EXP_NONE, EXP_ONE} exp_mode_e;
  typedef enum {ROW_TEXT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [BYTE_W-1:0] txt;
    bit                last;
    int                reps;
    exp_mode_e         mode;
    logic [BYTE_W-1:0] t_char;
    logic [OFS_W-1:0]  t_ofs;
    cfg_t              cfg;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  iwt_in_if  text_if ();
  iwt_out_if word_if ();
  iwt_cfg_if cfg_if ();

  index_word_tokenizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .text_i (text_if),
    .word_o (word_if)
  );

  always #2 clk_i = ~clk_i;

  // tokenizer model state
  cfg_t              tok_cfg;
  logic [BYTE_W-1:0] word_buf [MAX_WORD_DEF];
  int unsigned       word_len;
  logic [OFS_W-1:0]  byte_pos;
  logic [OFS_W-1:0]  word_start;
  bit                in_bracket;
  bit                after_lbracket;
  bit                skip_long;
  bit                swallow;

  char_item_t step_words [$];
  char_item_t expected_chars [$];
  plan_row_t  plan [$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  function automatic bit is_word_byte(logic [BYTE_W-1:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == CH_USCORE) ||
           (tok_cfg.index_digits && (b >= "0") && (b <= "9")) ||
           (tok_cfg.special_indexable &&
            ((b == CH_DASH) || (b == CH_LBRACK) || (b == CH_RBRACK)));
  endfunction

  function automatic void flush_word();
    for (int k = 0; k < word_len; k++) begin
      step_words.push_back('{word_buf[k], k == word_len - 1, word_start, SIZE_W'(word_len)});
    end
    word_len       = 0;
    in_bracket     = 1'b0;
    after_lbracket = 1'b0;
  endfunction

  function automatic void append_char(logic [BYTE_W-1:0] b, logic [OFS_W-1:0] p);
    if (word_len >= MAX_WORD_DEF) begin
      word_len       = 0;
      skip_long      = 1'b1;
      in_bracket     = 1'b0;
      after_lbracket = 1'b0;
      return;
    end
    if (word_len == 0) word_start = p;
    word_buf[word_len] = ((b >= "A") && (b <= "Z")) ? (b | 8'h20) : b;
    word_len++;
  endfunction

  // one text byte in, the char items it releases land in step_words
  function automatic void tokenize_byte(logic [BYTE_W-1:0] b, bit last);
    logic [OFS_W-1:0] p;
    p = byte_pos;
    byte_pos = byte_pos + 1'b1;
    step_words.delete();
    if (swallow) begin
      swallow = 1'b0;
    end else if (skip_long && is_word_byte(b)) begin
      // rest of a dropped long word
    end else begin
      skip_long = 1'b0;
      if (is_word_byte(b) || in_bracket) begin
        if (b == CH_LBRACK) begin
          after_lbracket = 1'b1;
          in_bracket     = 1'b1;
        end else begin
          after_lbracket = 1'b0;
          if (b == CH_RBRACK) in_bracket = 1'b0;
        end
        if ((b == CH_DASH) && !in_bracket) flush_word();
        else append_char(b, p);
      end else if (tok_cfg.special_indexable && (b == CH_CARET) && after_lbracket) begin
        after_lbracket = 1'b0;
        append_char(b, p);
      end else begin
        after_lbracket = 1'b0;
        flush_word();
        if (tok_cfg.interpret_special && (b == CH_BSLASH)) swallow = 1'b1;
      end
    end
    if (last) begin
      if (step_words.size() == 0) flush_word();
      word_len       = 0;
      in_bracket     = 1'b0;
      after_lbracket = 1'b0;
      skip_long      = 1'b0;
      swallow        = 1'b0;
    end
  endfunction

  function automatic void add_text(logic [BYTE_W-1:0] b, bit last, int reps);
    plan.push_back('{ROW_TEXT, b, last, reps, EXP_MODEL, 8'h00, '0, cfg_t'(3'b000)});
  endfunction

  function automatic void add_fixed(logic [BYTE_W-1:0] b, bit last, exp_mode_e mode,
                                    logic [BYTE_W-1:0] ch, logic [OFS_W-1:0] ofs);
    plan.push_back('{ROW_TEXT, b, last, 1, mode, ch, ofs, cfg_t'(3'b000)});
  endfunction

  function automatic void add_cfg(cfg_t c);
    plan.push_back('{ROW_CFG, 8'h00, 1'b0, 0, EXP_MODEL, 8'h00, '0, c});
  endfunction

  function automatic logic [BYTE_W-1:0] rand_word_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return BYTE_W'(8'h61 + r);
    if (r < 52) return BYTE_W'(8'h41 + r - 26);
    if (r < 62) return BYTE_W'(8'h30 + r - 52);
    return CH_USCORE;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(logic [BYTE_W-1:0] b, bit last, exp_mode_e mode,
                           logic [BYTE_W-1:0] ch, logic [OFS_W-1:0] ofs);
    while ($urandom_range(99) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.buffer_last <= last;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    tokenize_byte(b, last);
    case (mode)
      EXP_MODEL: foreach (step_words[k]) expected_chars.push_back(step_words[k]);
      EXP_ONE:   expected_chars.push_back('{ch, 1'b1, ofs, SIZE_W'(1)});
      default:   ;
    endcase
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_rand(logic [BYTE_W-1:0] b);
    send_byte(b, $urandom_range(29) == 0, EXP_MODEL, 8'h00, '0);
  endtask

  task automatic settle();
    text_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg_set(cfg_t c);
    cfg_idx_e regs [3] = '{CFG_INDEX_DIGITS, CFG_INTERPRET_SPECIAL, CFG_SPECIAL_INDEXABLE};
    logic     v;
    foreach (regs[k]) begin
      case (regs[k])
        CFG_INDEX_DIGITS:      v = c.index_digits;
        CFG_INTERPRET_SPECIAL: v = c.interpret_special;
        default:               v = c.special_indexable;
      endcase
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[k];
      cfg_if.data  <= v;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      case (regs[k])
        CFG_INDEX_DIGITS:      tok_cfg.index_digits = v;
        CFG_INTERPRET_SPECIAL: tok_cfg.interpret_special = v;
        default:               tok_cfg.special_indexable = v;
      endcase
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(cfg_t c, int idle_s, int stall_r, bit hold, int n_items);
    int kind;
    int len;
    int first;
    int paused_at;
    settle();
    write_cfg_set(c);
    send_idle_pct  = idle_s;
    recv_stall_pct = stall_r;
    if (hold) begin
      @(posedge clk_i);
      hold_left = HOLD_CYCLES;
      @(negedge clk_i);
    end
    first     = bytes_sent;
    paused_at = bytes_sent;
    while (bytes_sent - first < n_items) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        len = ($urandom_range(39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        repeat (len) send_rand(rand_word_char());
      end else if (kind < 58) begin
        send_rand(CH_LBRACK);
        if ($urandom_range(1)) send_rand(CH_CARET);
        repeat ($urandom_range(4)) send_rand(BYTE_W'($urandom_range(255)));
        if ($urandom_range(4) != 0) send_rand(CH_RBRACK);
      end else if (kind < 66) begin
        send_rand(CH_DASH);
      end else if (kind < 74) begin
        send_rand(CH_BSLASH);
        send_rand(BYTE_W'($urandom_range(255)));
      end else if (kind < 88) begin
        send_rand(BYTE_W'($urandom_range(32, 47)));
      end else begin
        send_rand(BYTE_W'($urandom_range(255)));
      end
      if (bytes_sent - paused_at >= PAUSE_EVERY) begin
        settle();
        paused_at = bytes_sent;
      end
    end
  endtask

  // output side ready, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      word_if.ready <= 1'b0;
      hold_left--;
    end else begin
      word_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    char_item_t want;
    if (rst_ni && word_if.valid && word_if.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected item char=%h last=%b ofs=%h size=%0d", $time,
                 word_if.word_char, word_if.word_last, word_if.word_offset, word_if.word_size);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (word_if.word_char !== want.ch) begin
          $display("%0t: word_char expected %h got %h", $time, want.ch, word_if.word_char);
          errors++;
        end
        if (word_if.word_last !== want.last) begin
          $display("%0t: word_last expected %b got %b", $time, want.last, word_if.word_last);
          errors++;
        end
        if (word_if.word_offset !== want.ofs) begin
          $display("%0t: word_offset expected %h got %h", $time, want.ofs,
                   word_if.word_offset);
          errors++;
        end
        if (word_if.word_size !== want.size) begin
          $display("%0t: word_size expected %0d got %0d", $time, want.size,
                   word_if.word_size);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (word_if.valid && word_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.buffer_last = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_INDEX_DIGITS;
    cfg_if.data         = 1'b0;
    word_if.ready       = 1'b0;
    tok_cfg             = cfg_t'(3'b000);
    word_len            = 0;
    byte_pos            = '0;
    word_start          = '0;
    in_bracket          = 1'b0;
    after_lbracket      = 1'b0;
    skip_long           = 1'b0;
    swallow             = 1'b0;

    // reset config, all options off
    add_fixed("A", 1'b0, EXP_NONE, 8'h00, '0);
    add_fixed(8'hFF, 1'b1, EXP_ONE, "a", 32'd0);
    add_fixed(8'h00, 1'b1, EXP_NONE, 8'h00, '0);
    add_text("Z", 1'b0, 1);
    add_text(CH_USCORE, 1'b0, 1);
    add_text("7", 1'b0, 1);
    add_cfg(cfg_t'(3'b111));
    add_text("9", 1'b0, 1);
    add_text("q", 1'b0, 1);
    add_text(CH_DASH, 1'b0, 1);
    add_text(CH_LBRACK, 1'b0, 1);
    add_text(CH_CARET, 1'b0, 1);
    add_text(" ", 1'b0, 1);
    add_text(CH_RBRACK, 1'b0, 1);
    add_text("X", 1'b0, 1);
    add_text(8'h00, 1'b0, 1);
    add_text(CH_BSLASH, 1'b0, 1);
    add_fixed("a", 1'b0, EXP_NONE, 8'h00, '0);
    add_text("b", 1'b0, 1);
    add_fixed(CH_BSLASH, 1'b1, EXP_ONE, "b", 32'd17);
    add_text("k", 1'b0, 70);
    add_fixed(".", 1'b0, EXP_NONE, 8'h00, '0);
    add_fixed("m", 1'b1, EXP_ONE, "m", 32'd90);
    add_text("W", 1'b0, 64);
    add_text("!", 1'b1, 1);
    add_text(CH_LBRACK, 1'b0, 1);
    add_text("a", 1'b0, 1);
    add_text(CH_CARET, 1'b0, 1);
    add_text(CH_DASH, 1'b0, 1);
    add_text("Q", 1'b1, 1);
    add_text(CH_CARET, 1'b0, 1);
    add_text("1", 1'b0, 1);
    add_text(CH_RBRACK, 1'b0, 1);
    add_text(8'h80, 1'b0, 1);
    add_cfg(cfg_t'(3'b000));
    add_text("d", 1'b0, 1);
    add_text(CH_BSLASH, 1'b0, 1);
    add_text("e", 1'b0, 1);
    add_text(CH_DASH, 1'b1, 1);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        settle();
        write_cfg_set(plan[r].cfg);
      end else begin
        repeat (plan[r].reps) begin
          send_byte(plan[r].txt, plan[r].last, plan[r].mode, plan[r].t_char, plan[r].t_ofs);
        end
      end
    end

    run_phase(cfg_t'(3'b111), 0, 0, 1'b0, PHASE_ITEMS);
    run_phase(cfg_t'(3'b000), 58, 0, 1'b0, PHASE_ITEMS);
    run_phase(cfg_t'(3'($urandom_range(7))), 0, 58, 1'b0, PHASE_ITEMS);
    run_phase(cfg_t'(3'($urandom_range(7))), 7, 7, 1'b0, PHASE_ITEMS);
    run_phase(cfg_t'(3'($urandom_range(7))), 0, 0, 1'b1, PHASE_ITEMS);
    settle();

    if ((errors == 0) && (expected_chars.size() == 0)) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/iwt_pkg.sv
hw/rtl/iwt_if.sv
hw/rtl/iwt_ram.sv
hw/rtl/iwt_front.sv
hw/rtl/iwt_desc_fifo.sv
hw/rtl/iwt_back.sv
hw/rtl/index_word_tokenizer.sv
verif/tb_top.sv
